[rtl/core/sdtq_pkg.sv]
// Shared types and constants for the sorted deadline timer queue.
// Used by the channel interfaces, the cell chain and the top level.
package sdtq_pkg;

   localparam int SLOT_W     = 4;
   localparam int DELAY_W    = 32;
   localparam int TIME_W     = 64;
   localparam int OWNER_W    = 8;
   localparam int SIGNAL_W   = 7;
   localparam int RAISE_W    = 6;

   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic KIND_EXPIRED = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [SIGNAL_W-1:0] MAX_SIGNAL_CODE = 7'd64;
   localparam logic [SIGNAL_W-1:0] NO_SIGNAL       = 7'd0;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [SLOT_W-1:0]   slot;
      logic [DELAY_W-1:0]  delay;
      logic [TIME_W-1:0]   now;
      logic [OWNER_W-1:0]  owner;
      logic [SIGNAL_W-1:0] signal_code;
   } req_type;

   typedef struct packed {
      logic                kind;
      logic [SLOT_W-1:0]   expired_slot;
      logic [OWNER_W-1:0]  expired_owner;
      logic                raise_valid;
      logic [RAISE_W-1:0]  raise_number;
      logic                alarm_update;
      logic                alarm_enabled;
      logic [TIME_W-1:0]   alarm_time;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]   deadline;
      logic [SIGNAL_W-1:0] signal_code;
   } cell_data_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SPREAD,
      CELL_REMOVE,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [SLOT_W-1:0]   slot;
      cell_data_type       data;
   } cell_cmd_type;

endpackage

[rtl/core/sdtq_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Payload types come from sdtq_pkg.
interface sdtq_req_if;
   logic                 valid;
   logic                 ready;
   sdtq_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sdtq_rsp_if;
   logic                 valid;
   logic                 ready;
   sdtq_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/sdtq_cell.sv]
// One cell of the sorted timer chain: holds one pending entry.
// Trades entries with its neighbours under a broadcast command from sdtq_pkg.
module sdtq_cell #(
   parameter int OWNER_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sdtq_pkg::cell_cmd_type  cmd,
   input  logic [OWNER_BITS-1:0]   ins_owner,
   input  logic                    left_valid,
   input  sdtq_pkg::cell_data_type left_data,
   input  logic [OWNER_BITS-1:0]   left_owner,
   input  logic                    left_flag,
   input  logic                    left_after,
   input  logic                    right_valid,
   input  sdtq_pkg::cell_data_type right_data,
   input  logic [OWNER_BITS-1:0]   right_owner,
   output logic                    valid,
   output sdtq_pkg::cell_data_type data,
   output logic [OWNER_BITS-1:0]   owner,
   output logic                    flag,
   output logic                    after
);

   logic                    valid_ff, valid_in;
   sdtq_pkg::cell_data_type data_ff, data_in;
   logic [OWNER_BITS-1:0]   owner_ff, owner_in;
   logic                    flag_ff, flag_in;
   logic                    match;

   assign match = valid_ff && (data_ff.slot == cmd.slot);
   assign after = valid_ff && (data_ff.deadline <= cmd.data.deadline);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      owner_in = owner_ff;
      flag_in  = flag_ff;
      case (cmd.op)
         sdtq_pkg::CELL_SPREAD: begin
            flag_in = flag_ff | left_flag | match;
         end
         sdtq_pkg::CELL_REMOVE: begin
            if (flag_ff) begin
               valid_in = right_valid;
               data_in  = right_data;
               owner_in = right_owner;
            end
            flag_in = 1'b0;
         end
         sdtq_pkg::CELL_POP: begin
            valid_in = right_valid;
            data_in  = right_data;
            owner_in = right_owner;
         end
         sdtq_pkg::CELL_INSERT: begin
            if (!after) begin
               if (left_after) begin
                  valid_in = 1'b1;
                  data_in  = cmd.data;
                  owner_in = ins_owner;
               end else begin
                  valid_in = left_valid;
                  data_in  = left_data;
                  owner_in = left_owner;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      owner_ff <= owner_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;
   assign owner = owner_ff;
   assign flag  = flag_ff;

endmodule

[rtl/core/sdtq_chain.sv]
// Row of sdtq_cell instances kept in ascending deadline order, head at cell 0.
// Depends on sdtq_pkg and sdtq_cell.
module sdtq_chain #(
   parameter int NUM_SLOTS  = 16,
   parameter int OWNER_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sdtq_pkg::cell_cmd_type  cmd,
   input  logic [OWNER_BITS-1:0]   ins_owner,
   output logic                    head_valid,
   output sdtq_pkg::cell_data_type head_data,
   output logic [OWNER_BITS-1:0]   head_owner
);

   logic                    valid_w [NUM_SLOTS];
   sdtq_pkg::cell_data_type data_w  [NUM_SLOTS];
   logic [OWNER_BITS-1:0]   owner_w [NUM_SLOTS];
   logic                    flag_w  [NUM_SLOTS];
   logic                    after_w [NUM_SLOTS];

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      logic                    lv, lf, la, rv;
      sdtq_pkg::cell_data_type ld, rd;
      logic [OWNER_BITS-1:0]   lo, ro;

      if (i == 0) begin : g_head
         assign lv = 1'b0;
         assign ld = cmd.data;
         assign lo = ins_owner;
         assign lf = 1'b0;
         assign la = 1'b1;
      end else begin : g_body
         assign lv = valid_w[i-1];
         assign ld = data_w[i-1];
         assign lo = owner_w[i-1];
         assign lf = flag_w[i-1];
         assign la = after_w[i-1];
      end

      if (i == NUM_SLOTS - 1) begin : g_tail
         assign rv = 1'b0;
         assign rd = cmd.data;
         assign ro = ins_owner;
      end else begin : g_mid
         assign rv = valid_w[i+1];
         assign rd = data_w[i+1];
         assign ro = owner_w[i+1];
      end

      sdtq_cell #(
         .OWNER_BITS (OWNER_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .ins_owner   (ins_owner),
         .left_valid  (lv),
         .left_data   (ld),
         .left_owner  (lo),
         .left_flag   (lf),
         .left_after  (la),
         .right_valid (rv),
         .right_data  (rd),
         .right_owner (ro),
         .valid       (valid_w[i]),
         .data        (data_w[i]),
         .owner       (owner_w[i]),
         .flag        (flag_w[i]),
         .after       (after_w[i])
      );
   end

   assign head_valid = valid_w[0];
   assign head_data  = data_w[0];
   assign head_owner = owner_w[0];

endmodule

[rtl/core/sorted_deadline_timer_queue.sv]
// Sorted deadline timer queue: top level with request sequencer and response register.
// Depends on sdtq_pkg, sdtq_if and sdtq_chain.
//
// Pending timers sit in a chain of NUM_SLOTS cells in ascending deadline order, with ties
// kept in arming order. Arming an idle slot runs the insert and status states.
// Cancelling a pending slot runs spread, remove and status, and re-arming a pending
// slot spread, remove, insert and status: the removal mark walks the chain one cell
// per cycle before the cells behind the removed entry close up. A check pops each
// expired entry from the head of the chain before the status response. A cancel of an
// idle slot, an out-of-range slot or an unused opcode goes straight to status. Responses
// wait in an output register; only a stalled response channel holds the sequencer.
module sorted_deadline_timer_queue #(
   parameter int NUM_SLOTS  = 16,
   parameter int OWNER_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   sdtq_req_if.sink    req_bus,
   sdtq_rsp_if.source  rsp_bus
);

   localparam int VALID_DEPTH = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
   localparam int VIDX_BITS   = $clog2(VALID_DEPTH);
   localparam int CNT_BITS    = $clog2(NUM_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPREAD,
      ST_REMOVE,
      ST_INSERT,
      ST_POP,
      ST_STATUS
   } state_type;

   state_type                        state_ff, state_in;
   logic [1:0]                       op_ff, op_in;
   logic [sdtq_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [sdtq_pkg::TIME_W-1:0]      deadline_ff, deadline_in;
   logic [sdtq_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [OWNER_BITS-1:0]            owner_ff, owner_in;
   logic [sdtq_pkg::SIGNAL_W-1:0]    signal_ff, signal_in;
   logic                             update_ff, update_in;
   logic [CNT_BITS-1:0]              cnt_ff, cnt_in;
   logic [VALID_DEPTH-1:0]           slot_valid_ff, slot_valid_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sdtq_pkg::rsp_type                rsp_ff, rsp_in;

   sdtq_pkg::cell_cmd_type           cmd;
   logic                             head_valid;
   sdtq_pkg::cell_data_type          head_data;
   logic [OWNER_BITS-1:0]            head_owner;

   logic                             req_fire;
   logic                             out_free;
   logic                             slot_in_range;
   logic [VIDX_BITS-1:0]             req_vidx, cur_vidx, head_vidx;
   logic                             expired;
   logic                             pop_go;
   logic                             raise;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign slot_in_range = int'(req_bus.payload.slot) < NUM_SLOTS;
   assign req_vidx      = req_bus.payload.slot[VIDX_BITS-1:0];
   assign cur_vidx      = slot_ff[VIDX_BITS-1:0];
   assign head_vidx     = head_data.slot[VIDX_BITS-1:0];
   assign expired       = head_valid && (head_data.deadline <= now_ff);
   assign pop_go        = (state_ff == ST_POP) && expired && out_free;
   assign raise         = (head_data.signal_code != sdtq_pkg::NO_SIGNAL) &&
                          (head_data.signal_code <= sdtq_pkg::MAX_SIGNAL_CODE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      deadline_in   = deadline_ff;
      now_in        = now_ff;
      owner_in      = owner_ff;
      signal_in     = signal_ff;
      update_in     = update_ff;
      cnt_in        = cnt_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_in        = rsp_ff;
      cmd.op               = sdtq_pkg::CELL_HOLD;
      cmd.slot             = slot_ff;
      cmd.data.slot        = slot_ff;
      cmd.data.deadline    = deadline_ff;
      cmd.data.signal_code = signal_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_bus.payload.opcode;
               slot_in     = req_bus.payload.slot;
               deadline_in = req_bus.payload.now +
                             sdtq_pkg::TIME_W'(req_bus.payload.delay);
               now_in      = req_bus.payload.now;
               owner_in    = OWNER_BITS'(req_bus.payload.owner);
               signal_in   = req_bus.payload.signal_code;
               update_in   = 1'b0;
               cnt_in      = '0;
               state_in    = ST_STATUS;
               case (req_bus.payload.opcode)
                  sdtq_pkg::OP_ARM: begin
                     if (slot_in_range) begin
                        update_in = 1'b1;
                        state_in  = slot_valid_ff[req_vidx] ? ST_SPREAD : ST_INSERT;
                     end
                  end
                  sdtq_pkg::OP_CANCEL: begin
                     if (slot_in_range && slot_valid_ff[req_vidx]) begin
                        update_in = 1'b1;
                        state_in  = ST_SPREAD;
                     end
                  end
                  sdtq_pkg::OP_CHECK: begin
                     state_in = ST_POP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SPREAD: begin
            cmd.op = sdtq_pkg::CELL_SPREAD;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(NUM_SLOTS - 1)) begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            cmd.op                  = sdtq_pkg::CELL_REMOVE;
            slot_valid_in[cur_vidx] = 1'b0;
            state_in = (op_ff == sdtq_pkg::OP_ARM) ? ST_INSERT : ST_STATUS;
         end
         ST_INSERT: begin
            cmd.op                  = sdtq_pkg::CELL_INSERT;
            slot_valid_in[cur_vidx] = 1'b1;
            state_in                = ST_STATUS;
         end
         ST_POP: begin
            if (!expired) begin
               state_in = ST_STATUS;
            end else if (out_free) begin
               cmd.op                   = sdtq_pkg::CELL_POP;
               slot_valid_in[head_vidx] = 1'b0;
               update_in                = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_in.kind              = sdtq_pkg::KIND_EXPIRED;
               rsp_in.expired_slot      = head_data.slot;
               rsp_in.expired_owner     = sdtq_pkg::OWNER_W'(head_owner);
               rsp_in.raise_valid       = raise;
               rsp_in.raise_number      = raise ?
                  sdtq_pkg::RAISE_W'(head_data.signal_code - 1'b1) : '0;
               rsp_in.alarm_update      = 1'b0;
               rsp_in.alarm_enabled     = 1'b0;
               rsp_in.alarm_time        = '0;
               rsp_in.last              = 1'b0;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = sdtq_pkg::KIND_STATUS;
               rsp_in.expired_slot  = '0;
               rsp_in.expired_owner = '0;
               rsp_in.raise_valid   = 1'b0;
               rsp_in.raise_number  = '0;
               rsp_in.alarm_update  = update_ff;
               rsp_in.alarm_enabled = head_valid;
               rsp_in.alarm_time    = head_valid ? head_data.deadline : '0;
               rsp_in.last          = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         update_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         update_ff     <= update_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      deadline_ff <= deadline_in;
      now_ff      <= now_in;
      owner_ff    <= owner_in;
      signal_ff   <= signal_in;
      rsp_ff      <= rsp_in;
   end

   sdtq_chain #(
      .NUM_SLOTS  (NUM_SLOTS),
      .OWNER_BITS (OWNER_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .ins_owner  (owner_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_owner (head_owner)
   );

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   a_head_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (head_valid == (|slot_valid_ff)))
      else $error("chain head disagrees with slot valid bits");

   a_pop_of_pending: assert property (@(posedge clock) disable iff (reset)
      pop_go |-> slot_valid_ff[head_vidx])
      else $error("popped entry of an idle slot");

   a_insert_idle_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> !slot_valid_ff[cur_vidx])
      else $error("insert of a slot still pending");

   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last == rsp_ff.kind))
      else $error("last flag not on the status response");

   a_disabled_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.alarm_enabled) |-> (rsp_ff.alarm_time == '0))
      else $error("alarm time set while alarm disabled");

endmodule
